>>> hw/rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Code values, decoder phases and response status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

  localparam int unsigned MIN_CODE_WIDTH = 9;

  localparam logic [8:0] CODE_CLEAR      = 9'h100;
  localparam logic [8:0] CODE_END        = 9'h101;
  localparam logic [8:0] CODE_FIRST_FREE = 9'h102;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_FIRST   = 3'd0;
  localparam phase_t PH_LITERAL = 3'd1;
  localparam phase_t PH_NORMAL  = 3'd2;
  localparam phase_t PH_END     = 3'd3;
  localparam phase_t PH_ERROR   = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t ST_BYTE      = 3'd0;
  localparam status_t ST_NEED_IN   = 3'd1;
  localparam status_t ST_END       = 3'd2;
  localparam status_t ST_ERROR     = 3'd3;
  localparam status_t ST_LOAD_OK   = 3'd4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PULL = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/lzwd_if.sv
// ----------------------------------------------------------------------------
// LZW decoder channels
// Request channel (load or pull) and response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, req_type, in_byte, input ready);
  modport sink   (input valid, req_type, in_byte, output ready);
endinterface

interface lzwd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       string_end;

  modport source (output valid, out_byte, status, string_end, input ready);
  modport sink   (input valid, out_byte, status, string_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lzw_decoder_9_to_12_bit_core.sv
// ----------------------------------------------------------------------------
// LZW decoder core, 9 to 12 bit codes
// Pull-model LZW decompressor with dictionary and reverse stack in RAM.
// ----------------------------------------------------------------------------
// Each request beat either loads one compressed byte or pulls one decoded
// byte. A pull with bytes waiting on the reverse stack passes the decide,
// pop and response states, the pop waiting on the registered stack RAM
// read. A pull with an empty stack decodes codes until bytes appear or it
// needs input, ends or fails; a dictionary code's chain is walked link by
// link through the single read port of the dictionary RAM, so a long string
// is walked onto the stack once and then pulled byte by byte. Requests are
// taken only while the sequencer is idle; a response beat waits in the
// output register and does not block the next request. No clearing pass
// after reset: RAM contents are only read where written.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_decoder_9_to_12_bit_core #(
  parameter int unsigned TABLE_ENTRIES  = 4096,
  parameter int unsigned MAX_CODE_WIDTH = 12
) (
  input wire logic  clk,
  input wire logic  rst,
  lzwd_req_if.sink  req,
  lzwd_rsp_if.source rsp
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned CW_W  = $clog2(MAX_CODE_WIDTH + 2);
  localparam int unsigned DW    = 8 + MAX_CODE_WIDTH;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_WALKRD = 3'd4;
  localparam logic [2:0] S_KWFIX  = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]                state, state_next;
  logic [31:0]               bit_buffer;
  logic [5:0]                bit_count;
  logic [CW_W-1:0]           code_width;
  logic [CNT_W-1:0]          next_free;
  logic [CNT_W-1:0]          stack_count;
  logic [MAX_CODE_WIDTH-1:0] previous_code;
  logic [MAX_CODE_WIDTH-1:0] code;       // code under decode
  logic [MAX_CODE_WIDTH-1:0] cur;        // chain walk position
  logic [7:0]                first_byte;
  logic                      kwkwk;
  lzwd_pkg::phase_t          phase;

  // pending response
  logic [7:0]                res_byte;
  lzwd_pkg::status_t         res_status;
  logic                      res_end;

  // output register
  logic                      out_valid;
  logic [7:0]                out_byte;
  lzwd_pkg::status_t         out_status;
  logic                      out_end;

  // RAM ports
  logic                      st_we;
  logic [IDX_W-1:0]          st_waddr, st_raddr;
  logic [7:0]                st_wdata, st_rdata;
  logic                      dc_we;
  logic [IDX_W-1:0]          dc_waddr, dc_raddr;
  logic [DW-1:0]             dc_wdata, dc_rdata;

  // code extraction
  logic [31:0]               mask;
  logic [MAX_CODE_WIDTH-1:0] v;
  logic                      have_code;
  logic                      push_ok;
  logic [CNT_W-1:0]          nf_inc;

  assign mask      = (32'h1 << code_width) - 32'h1;
  assign v         = MAX_CODE_WIDTH'(bit_buffer & mask);
  assign have_code = 6'(code_width) <= bit_count;
  assign push_ok   = stack_count < CNT_W'(TABLE_ENTRIES);
  assign nf_inc    = next_free + CNT_W'(1);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.out_byte   = out_byte;
  assign rsp.status     = out_status;
  assign rsp.string_end = out_end;

  lzwd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lzwd_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (dc_we),
    .waddr (dc_waddr),
    .wdata (dc_wdata),
    .raddr (dc_raddr),
    .rdata (dc_rdata)
  );

  // RAM port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = stack_count[IDX_W-1:0];
    st_wdata = 8'(v);
    st_raddr = IDX_W'(stack_count - CNT_W'(1));
    dc_we    = 1'b0;
    dc_waddr = next_free[IDX_W-1:0];
    dc_wdata = {first_byte, previous_code};
    dc_raddr = IDX_W'(cur);
    unique case (state)
      S_DECIDE: begin
        // literal push straight from the bit buffer
        st_we = (stack_count == '0) && (phase == lzwd_pkg::PH_LITERAL) && have_code &&
                (v[MAX_CODE_WIDTH-1:8] == '0) && push_ok;
      end
      S_WALK: begin
        st_we    = (cur[MAX_CODE_WIDTH-1:8] == '0) && push_ok;
        st_wdata = cur[7:0];
      end
      S_WALKRD: begin
        st_we    = push_ok;
        st_wdata = dc_rdata[DW-1:MAX_CODE_WIDTH];
      end
      S_KWFIX: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = first_byte;
      end
      S_ADD: begin
        dc_we = next_free < CNT_W'(TABLE_ENTRIES);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = (req.req_type == lzwd_pkg::REQ_LOAD) ?
                                           S_RESP : S_DECIDE;
      S_DECIDE: begin
        if (stack_count != '0) begin
          state_next = S_POP;
        end else if (phase == lzwd_pkg::PH_END || phase == lzwd_pkg::PH_ERROR ||
                     !have_code) begin
          state_next = S_RESP;
        end else if (phase == lzwd_pkg::PH_NORMAL &&
                     32'(v) != 32'(lzwd_pkg::CODE_CLEAR) &&
                     32'(v) != 32'(lzwd_pkg::CODE_END) &&
                     32'(v) <= 32'(next_free)) begin
          state_next = S_WALK;
        end
      end
      S_POP:    state_next = S_RESP;
      S_WALK:   if (cur[MAX_CODE_WIDTH-1:8] != '0) begin
                  state_next = S_WALKRD;
                end else begin
                  state_next = kwkwk ? S_KWFIX : S_ADD;
                end
      S_WALKRD: state_next = S_WALK;
      S_KWFIX:  state_next = S_ADD;
      S_ADD:    state_next = S_DECIDE;
      S_RESP:   if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bit_buffer    <= '0;
      bit_count     <= '0;
      code_width    <= CW_W'(lzwd_pkg::MIN_CODE_WIDTH);
      next_free     <= CNT_W'(lzwd_pkg::CODE_FIRST_FREE);
      stack_count   <= '0;
      previous_code <= '0;
      phase         <= lzwd_pkg::PH_FIRST;
      kwkwk         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      // drop the output beat once taken, unless a new one replaces it
      if (out_valid && rsp.ready && state != S_RESP) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          res_byte <= '0;
          res_end  <= 1'b0;
          if (req.valid && req.req_type == lzwd_pkg::REQ_LOAD) begin
            if (phase == lzwd_pkg::PH_END) begin
              res_status <= lzwd_pkg::ST_END;
            end else if (phase == lzwd_pkg::PH_ERROR || bit_count > 6'd24) begin
              res_status <= lzwd_pkg::ST_ERROR;
            end else begin
              bit_buffer <= bit_buffer | (32'(req.in_byte) << bit_count);
              bit_count  <= bit_count + 6'd8;
              res_status <= lzwd_pkg::ST_LOAD_OK;
            end
          end
        end

        S_DECIDE: begin
          if (stack_count != '0) begin
            // pop: read address already on the port
            stack_count <= stack_count - CNT_W'(1);
            res_end     <= (stack_count == CNT_W'(1));
            res_status  <= lzwd_pkg::ST_BYTE;
          end else if (phase == lzwd_pkg::PH_END) begin
            res_status <= lzwd_pkg::ST_END;
          end else if (phase == lzwd_pkg::PH_ERROR) begin
            res_status <= lzwd_pkg::ST_ERROR;
          end else if (!have_code) begin
            res_status <= lzwd_pkg::ST_NEED_IN;
          end else begin
            // consume one code
            bit_buffer <= bit_buffer >> code_width;
            bit_count  <= bit_count - 6'(code_width);
            code       <= v;
            if (phase == lzwd_pkg::PH_FIRST) begin
              if (32'(v) == 32'(lzwd_pkg::CODE_CLEAR)) begin
                code_width <= CW_W'(lzwd_pkg::MIN_CODE_WIDTH);
                next_free  <= CNT_W'(lzwd_pkg::CODE_FIRST_FREE);
                phase      <= lzwd_pkg::PH_LITERAL;
              end else begin
                phase <= lzwd_pkg::PH_ERROR;
              end
            end else if (32'(v) == 32'(lzwd_pkg::CODE_CLEAR)) begin
              code_width <= CW_W'(lzwd_pkg::MIN_CODE_WIDTH);
              next_free  <= CNT_W'(lzwd_pkg::CODE_FIRST_FREE);
              phase      <= lzwd_pkg::PH_LITERAL;
            end else if (32'(v) == 32'(lzwd_pkg::CODE_END)) begin
              phase <= lzwd_pkg::PH_END;
            end else if (phase == lzwd_pkg::PH_LITERAL) begin
              if (v[MAX_CODE_WIDTH-1:8] != '0) begin
                phase <= lzwd_pkg::PH_ERROR;
              end else begin
                if (push_ok) stack_count <= stack_count + CNT_W'(1);
                previous_code <= v;
                phase         <= lzwd_pkg::PH_NORMAL;
              end
            end else if (32'(v) < 32'(next_free)) begin
              cur   <= v;
              kwkwk <= 1'b0;
            end else if (32'(v) == 32'(next_free)) begin
              // KwKwK: reserve the bottom slot, walk the previous string
              stack_count <= CNT_W'(1);
              cur         <= previous_code;
              kwkwk       <= 1'b1;
            end else begin
              phase <= lzwd_pkg::PH_ERROR;
            end
          end
        end

        S_POP: begin
          res_byte <= st_rdata;
        end

        S_WALK: begin
          if (cur[MAX_CODE_WIDTH-1:8] == '0) begin
            if (push_ok) stack_count <= stack_count + CNT_W'(1);
            first_byte <= cur[7:0];
          end
        end

        S_WALKRD: begin
          if (push_ok) stack_count <= stack_count + CNT_W'(1);
          cur <= dc_rdata[MAX_CODE_WIDTH-1:0];
        end

        S_KWFIX: begin
        end

        S_ADD: begin
          if (next_free >= CNT_W'(TABLE_ENTRIES)) begin
            phase <= lzwd_pkg::PH_ERROR;
          end else begin
            next_free <= nf_inc;
            if ((nf_inc >> code_width) != '0) begin
              code_width <= code_width + CW_W'(1);
              if (code_width >= CW_W'(MAX_CODE_WIDTH)) phase <= lzwd_pkg::PH_ERROR;
            end
          end
          previous_code <= code;
        end

        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_byte   <= res_byte;
            out_status <= res_status;
            out_end    <= res_end;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // the stack never holds more than the table
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(TABLE_ENTRIES))
    else $error("reverse stack count beyond table size");

  // a beat that is not a byte carries no byte and no string end
  a_nonbyte_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != lzwd_pkg::ST_BYTE) |-> (out_byte == 8'd0 && !out_end))
    else $error("non-byte response carries byte data");

  // free codes never fall below the first dictionary entry
  a_free_floor: assert property (@(posedge clk) disable iff (rst)
    next_free >= CNT_W'(lzwd_pkg::CODE_FIRST_FREE))
    else $error("next free code below first entry");

  // requests are only taken by an idle sequencer, which then leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request taken without leaving idle");

endmodule

`default_nettype wire

>>> bench/lzwd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW decoder checker
// Watches the request and response channels, predicts every response beat
// with its own dictionary, bit buffer and reverse stack, and compares the
// responses in order. Hands the failure count and the backlog to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_checker (
  input  wire logic clk,
  input  wire logic rst,
  lzwd_req_if       req,
  lzwd_rsp_if       rsp,
  output int        errors,
  output int        pending
);

  localparam int TABLE_ENTRIES  = 4096;
  localparam int MAX_CODE_WIDTH = 12;

  typedef struct packed {
    logic [7:0]        data;
    lzwd_pkg::status_t status;
    logic              last;
  } rsp_beat_t;

  rsp_beat_t   awaited[$];

  logic [7:0]  dict_tail [TABLE_ENTRIES];
  logic [11:0] dict_link [TABLE_ENTRIES];
  logic [7:0]  stage     [TABLE_ENTRIES];
  int          stage_n;
  logic [31:0] bitbuf;
  int          bitcnt;
  int          width;
  int          free_code;
  int          last_code;
  lzwd_pkg::phase_t phase;

  task automatic stage_push(input int b);
    if (stage_n < TABLE_ENTRIES) begin
      stage[stage_n] = b[7:0];
      stage_n++;
    end
  endtask

  // Stack the string of a code, root byte on top; return its first byte.
  task automatic unroll(input int c, output int first);
    int g;
    g = 0;
    while (c > 255 && c < TABLE_ENTRIES && g < TABLE_ENTRIES) begin
      stage_push(dict_tail[c]);
      c = dict_link[c];
      g++;
    end
    stage_push(c);
    first = c & 255;
  endtask

  task automatic grow(input int tail, input int link);
    if (free_code >= TABLE_ENTRIES) begin
      phase = lzwd_pkg::PH_ERROR;
    end else begin
      dict_tail[free_code] = tail[7:0];
      dict_link[free_code] = link[11:0];
      free_code++;
      if (free_code >= (1 << width)) begin
        width++;
        if (width > MAX_CODE_WIDTH) phase = lzwd_pkg::PH_ERROR;
      end
    end
  endtask

  task automatic take_code(input int c);
    int first;
    if (phase == lzwd_pkg::PH_FIRST) begin
      if (c == int'(lzwd_pkg::CODE_CLEAR)) begin
        width = lzwd_pkg::MIN_CODE_WIDTH;
        free_code = int'(lzwd_pkg::CODE_FIRST_FREE);
        phase = lzwd_pkg::PH_LITERAL;
      end else begin
        phase = lzwd_pkg::PH_ERROR;
      end
    end else if (c == int'(lzwd_pkg::CODE_CLEAR)) begin
      width = lzwd_pkg::MIN_CODE_WIDTH;
      free_code = int'(lzwd_pkg::CODE_FIRST_FREE);
      phase = lzwd_pkg::PH_LITERAL;
    end else if (c == int'(lzwd_pkg::CODE_END)) begin
      phase = lzwd_pkg::PH_END;
    end else if (phase == lzwd_pkg::PH_LITERAL) begin
      if (c > 255) begin
        phase = lzwd_pkg::PH_ERROR;
      end else begin
        stage_push(c); last_code = c; phase = lzwd_pkg::PH_NORMAL;
      end
    end else if (c < free_code) begin
      unroll(c, first);
      grow(first, last_code);
      last_code = c;
    end else if (c == free_code) begin
      // string of the previous code plus its own first byte
      stage_n = 1;
      unroll(last_code, first);
      stage[0] = first[7:0];
      grow(first, last_code);
      last_code = c;
    end else begin
      phase = lzwd_pkg::PH_ERROR;
    end
  endtask

  task automatic predict(input logic kind, input logic [7:0] b, output rsp_beat_t r);
    int c;
    r = '0;
    if (kind == lzwd_pkg::REQ_LOAD) begin
      if (phase == lzwd_pkg::PH_END) r.status = lzwd_pkg::ST_END;
      else if (phase == lzwd_pkg::PH_ERROR || bitcnt > 24) r.status = lzwd_pkg::ST_ERROR;
      else begin
        bitbuf = bitbuf | (32'(b) << bitcnt);
        bitcnt += 8;
        r.status = lzwd_pkg::ST_LOAD_OK;
      end
      return;
    end
    while (stage_n == 0) begin
      if (phase == lzwd_pkg::PH_END) begin r.status = lzwd_pkg::ST_END; return; end
      if (phase == lzwd_pkg::PH_ERROR) begin r.status = lzwd_pkg::ST_ERROR; return; end
      if (bitcnt < width) begin r.status = lzwd_pkg::ST_NEED_IN; return; end
      c = int'(bitbuf & ((32'd1 << width) - 32'd1));
      bitbuf = bitbuf >> width;
      bitcnt -= width;
      take_code(c);
    end
    stage_n--;
    r.data   = stage[stage_n];
    r.status = lzwd_pkg::ST_BYTE;
    r.last   = (stage_n == 0);
  endtask

  always @(posedge clk) begin
    rsp_beat_t want, got;
    if (rst) begin
      stage_n = 0; bitbuf = '0; bitcnt = 0; width = lzwd_pkg::MIN_CODE_WIDTH;
      free_code = int'(lzwd_pkg::CODE_FIRST_FREE); last_code = 0;
      phase = lzwd_pkg::PH_FIRST;
      awaited.delete();
      errors = 0;
    end else begin
      if (req.valid && req.ready) begin
        predict(req.req_type, req.in_byte, want);
        awaited.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_byte, rsp.status, rsp.string_end};
        if (awaited.size() == 0) begin
          $display("%0t: response beat with none awaited: byte %0h status %0d end %0b",
                   $time, got.data, got.status, got.last);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (got.data !== want.data) begin
            $display("%0t: out_byte expected %0h actual %0h", $time, want.data, got.data);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: string_end expected %0b actual %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW decoder core testbench
// Encodes a well-formed variable-width code stream on the fly, loads it byte
// by byte and pulls each decoded string back out; ends with a stream end or
// a garbage tail. A checker module predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int RANDOM_BEATS  = 1400;
  localparam int STALL_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 300;
  localparam int KWK_PICK      = -1;  // directed plan: code equal to next free
  localparam int NEWEST_PICK   = -2;  // directed plan: newest dictionary entry

  typedef struct {
    int end_bit;
    int bytes_out;
  } due_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   beats;
  int   quiet_cycles;
  bit   calm;
  bit   hold_go;

  lzwd_req_if req ();
  lzwd_rsp_if rsp ();

  lzw_decoder_9_to_12_bit_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lzwd_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  // Encoder-side mirror of the dictionary: only string lengths are needed
  // to know how many pulls each code will answer with bytes.
  int          str_len [4096];
  int          enc_width;
  int          enc_free;
  int          enc_prev;
  bit          enc_literal;
  logic [63:0] acc;
  int          acc_n;
  int          bits_made;
  int          bits_loaded;
  due_t        due_q[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  // Offer one beat and hold it until taken; idle first now and then.
  task automatic send_beat(input logic kind, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 13) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.in_byte  <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    beats++;
    // calm stretch in the middle of the run
    calm = (beats >= 500 && beats < 800);
    if (beats == 300) hold_go = 1;
    if (beats == 900) begin
      // pause until every response beat is back
      req.valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
  endtask

  function automatic int len_of(input int c);
    return (c < 256) ? 1 : str_len[c];
  endfunction

  // Pull out every code whose bits are fully loaded, then maybe one extra
  // pull that should find the stack empty.
  task automatic drain_due();
    due_t d;
    while (due_q.size() != 0 && due_q[0].end_bit <= bits_loaded) begin
      d = due_q.pop_front();
      repeat (d.bytes_out) send_beat(lzwd_pkg::REQ_PULL, 8'($urandom));
    end
    if ($urandom_range(99) < 8) send_beat(lzwd_pkg::REQ_PULL, 8'($urandom));
  endtask

  // Append a code LSB-first, load every complete byte, pull what is ready.
  task automatic emit_code(input int c, input int n_out);
    acc       = acc | (64'(c) << acc_n);
    acc_n    += enc_width;
    bits_made += enc_width;
    due_q.push_back('{bits_made, n_out});
    while (acc_n >= 8) begin
      send_beat(lzwd_pkg::REQ_LOAD, acc[7:0]);
      acc = acc >> 8;
      acc_n -= 8;
      bits_loaded += 8;
    end
    drain_due();
  endtask

  task automatic flush_bits();
    if (acc_n > 0) begin
      send_beat(lzwd_pkg::REQ_LOAD, acc[7:0]);
      bits_loaded += acc_n;
      acc = '0;
      acc_n = 0;
    end
    drain_due();
  endtask

  // Emit one code and advance the encoder mirror exactly as the decoder will.
  task automatic put_code(input int c);
    int n;
    if (c == int'(lzwd_pkg::CODE_CLEAR) || c == int'(lzwd_pkg::CODE_END)) begin
      emit_code(c, 0);
      if (c == int'(lzwd_pkg::CODE_CLEAR)) begin
        enc_width = lzwd_pkg::MIN_CODE_WIDTH;
        enc_free = int'(lzwd_pkg::CODE_FIRST_FREE);
        enc_literal = 1;
      end
    end else if (enc_literal) begin
      emit_code(c, 1);
      enc_prev = c;
      enc_literal = 0;
    end else begin
      n = (c == enc_free) ? len_of(enc_prev) + 1 : len_of(c);
      emit_code(c, n);
      if (enc_free < 4096) begin
        str_len[enc_free] = len_of(enc_prev) + 1;
        enc_free++;
        if (enc_free >= (1 << enc_width)) enc_width++;
      end
      enc_prev = c;
    end
  endtask

  function automatic int pick_code();
    int roll;
    roll = $urandom_range(999);
    if (enc_literal) begin
      return (roll < 30) ? int'(lzwd_pkg::CODE_CLEAR) : int'($urandom_range(255));
    end
    // keep clear of the table limit
    if (roll < 7 || (enc_width == 12 && enc_free >= 4000)) return int'(lzwd_pkg::CODE_CLEAR);
    if (roll < 107) return enc_free;
    if (roll < 407) return int'($urandom_range(255));
    if (enc_free == int'(lzwd_pkg::CODE_FIRST_FREE) || roll < 607) begin
      return (enc_free - 1 < int'(lzwd_pkg::CODE_FIRST_FREE)) ?
             int'($urandom_range(255)) : enc_free - 1;
    end
    return int'($urandom_range(int'(lzwd_pkg::CODE_FIRST_FREE), enc_free - 1));
  endfunction

  initial begin
    int plan[$];
    int c;
    beats = 0; calm = 0; hold_go = 0; quiet_cycles = 0;
    acc = '0; acc_n = 0; bits_made = 0; bits_loaded = 0;
    enc_width = lzwd_pkg::MIN_CODE_WIDTH; enc_free = int'(lzwd_pkg::CODE_FIRST_FREE);
    enc_prev = 0; enc_literal = 1;
    req.valid = 1'b0;
    req.req_type = lzwd_pkg::REQ_LOAD;
    req.in_byte = '0;
    @(negedge rst);
    @(posedge clk);

    // Directed opening: pull on an empty buffer, clear first, literal
    // extremes, back-to-back clears, the KwKwK case and the newest entry.
    send_beat(lzwd_pkg::REQ_PULL, 8'h00);
    plan = '{int'(lzwd_pkg::CODE_CLEAR), 0, int'(lzwd_pkg::CODE_CLEAR),
             int'(lzwd_pkg::CODE_CLEAR), 255, KWK_PICK,
             65, NEWEST_PICK, KWK_PICK, 0, NEWEST_PICK};
    foreach (plan[i]) begin
      c = plan[i];
      if (c == KWK_PICK) c = enc_free;
      else if (c == NEWEST_PICK) c = enc_free - 1;
      put_code(c);
    end

    // Random stream: well-formed codes with random content.
    while (beats < RANDOM_BEATS) put_code(pick_code());

    // Finish either with a proper stream end or with a garbage tail that
    // overfills the bit buffer and drives the decoder into error.
    if ($urandom_range(1)) begin
      put_code(int'(lzwd_pkg::CODE_END));
      flush_bits();
      repeat (4) send_beat(lzwd_pkg::REQ_PULL, 8'($urandom));
      repeat (3) send_beat(lzwd_pkg::REQ_LOAD, 8'($urandom));
    end else begin
      flush_bits();
      repeat (40) send_beat(($urandom_range(99) < 45) ? lzwd_pkg::REQ_PULL :
                            lzwd_pkg::REQ_LOAD, 8'($urandom));
      repeat (5) send_beat(lzwd_pkg::REQ_LOAD, 8'($urandom));
      repeat (20) send_beat(lzwd_pkg::REQ_PULL, 8'($urandom));
    end
    req.valid <= 1'b0;

    // Drain, then let the core settle a little longer.
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
